@@ rtl/fse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Format string expander package
// Shared types, character codes and the digit-to-character mapping.
// ----------------------------------------------------------------------------
package fse_pkg;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_MINUS   = 8'h2d;
   localparam logic [7:0] CHAR_C       = 8'h63;
   localparam logic [7:0] CHAR_D       = 8'h64;
   localparam logic [7:0] CHAR_S       = 8'h73;
   localparam logic [7:0] CHAR_X       = 8'h78;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   localparam int ARG_WIDTH   = 32;
   localparam int BCD_DIGITS  = 10;
   localparam int HEX_DIGITS  = 8;
   localparam int DIGIT_WIDTH = 4;
   localparam int DIGITS_WIDTH = BCD_DIGITS * DIGIT_WIDTH;
   localparam int COUNT_WIDTH  = $clog2(ARG_WIDTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_EMIT
   } fse_state_type;

   typedef struct packed {
      logic                    done;
      logic [DIGITS_WIDTH-1:0] digits;
   } fse_bcd_status_type;

   function automatic logic [7:0] digit_char(input logic [DIGIT_WIDTH-1:0] nib);
      logic [7:0] ext;
      ext = {4'd0, nib};
      if (nib < 4'd10) begin
         digit_char = CHAR_ZERO + ext;
      end else begin
         digit_char = CHAR_LOWER_A + ext - 8'd10;
      end
   endfunction

endpackage

@@ rtl/fse_bcd.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial binary to BCD converter
// Shifts the binary value in one bit per cycle, adjusting each decimal digit
// on the way, and flags the ten-digit result once all thirty-two bits are in.
// ----------------------------------------------------------------------------
module fse_bcd (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [fse_pkg::ARG_WIDTH-1:0]        value,
   output fse_pkg::fse_bcd_status_type          status
);

   logic [fse_pkg::ARG_WIDTH-1:0]    bin_ff, bin_in;
   logic [fse_pkg::DIGITS_WIDTH-1:0] bcd_ff, bcd_in, adj;
   logic [fse_pkg::COUNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;

   always_comb begin
      for (int i = 0; i < fse_pkg::BCD_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = value;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in = {adj[fse_pkg::DIGITS_WIDTH-2:0], bin_ff[fse_pkg::ARG_WIDTH-1]};
         bin_in = {bin_ff[fse_pkg::ARG_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff + {{(fse_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1};
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
   end

   assign status.done   = done_ff;
   assign status.digits = bcd_ff;

endmodule

@@ rtl/format_string_expander.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Format string expander
// Expands a printf-style character stream supporting the c, s, d and x
// conversions into a stream of output characters with a running count.
// ----------------------------------------------------------------------------
// The req channel carries one format or string-argument character per
// transaction, with the conversion argument alongside; req_tuser marks a
// string-argument character. The rsp channel returns one character per
// transaction, with tlast on the final character that an input causes and a
// saturating running count of characters in the upper bits of tdata.
// A plain character, a string character or a c conversion appears on rsp in the
// cycle after it is accepted, and such inputs can follow back to back.
// An x conversion is accepted, then skips the leading zero nibbles, changes
// over and emits the remaining digits one by one. A d conversion is accepted,
// then shifts through the bit-serial BCD converter, collects the digits,
// skips the leading zeros, changes over and emits a minus sign if needed and
// then the remaining digits; skipped zeros and digits always add up to ten.
// One input is handled at a time: req_tready is high only when the block is
// idle and its output register is free. Reset clears the pending percent
// flag and the running count. A stalled receiver holds the output register
// and the emission of characters simply waits for it.
// ----------------------------------------------------------------------------
module format_string_expander (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // char_code [7:0], arg_bits [39:8]
   input  logic [0:0]  req_tuser,   // mode [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_char [7:0], chars_so_far [39:8]
   output logic        rsp_tlast
);

   fse_pkg::fse_state_type            state_ff, state_in;
   logic                              pend_ff, pend_in;
   logic                              neg_ff, neg_in;
   logic [31:0]                       total_ff, total_in;
   logic [fse_pkg::DIGITS_WIDTH-1:0]  digits_ff, digits_in;
   logic [3:0]                        cnt_ff, cnt_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [7:0]                        rsp_char_ff, rsp_char_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic [31:0]                       rsp_count_ff, rsp_count_in;

   logic                              out_free;
   logic                              accept;
   logic                              emit;
   logic [7:0]                        emit_char;
   logic                              emit_last;
   logic                              bcd_start;
   logic [31:0]                       magnitude;
   logic [7:0]                        ch;
   logic [31:0]                       arg;
   logic [3:0]                        top_nib;
   fse_pkg::fse_bcd_status_type       bcd_status;

   assign ch        = req_tdata[7:0];
   assign arg       = req_tdata[39:8];
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == fse_pkg::ST_IDLE) && out_free;
   assign accept    = req_tvalid && req_tready;
   assign magnitude = arg[31] ? (32'd0 - arg) : arg;
   assign top_nib   = digits_ff[fse_pkg::DIGITS_WIDTH-1 -: 4];

   fse_bcd u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (bcd_start),
      .value  (magnitude),
      .status (bcd_status)
   );

   always_comb begin
      state_in  = state_ff;
      pend_in   = pend_ff;
      neg_in    = neg_ff;
      digits_in = digits_ff;
      cnt_in    = cnt_ff;
      emit      = 1'b0;
      emit_char = ch;
      emit_last = 1'b1;
      bcd_start = 1'b0;
      case (state_ff)
         fse_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_tuser[0]) begin
                  emit = 1'b1;
               end else if (!pend_ff) begin
                  if (ch == fse_pkg::CHAR_PERCENT) begin
                     pend_in = 1'b1;
                  end else begin
                     emit = 1'b1;
                  end
               end else begin
                  pend_in = 1'b0;
                  if (ch == fse_pkg::CHAR_C) begin
                     emit      = 1'b1;
                     emit_char = arg[7:0];
                  end else if (ch == fse_pkg::CHAR_S) begin
                     emit = 1'b0;
                  end else if (ch == fse_pkg::CHAR_D) begin
                     neg_in    = arg[31];
                     bcd_start = 1'b1;
                     state_in  = fse_pkg::ST_CONV;
                  end else if (ch == fse_pkg::CHAR_X) begin
                     neg_in    = 1'b0;
                     digits_in = {arg, 8'd0};
                     cnt_in    = 4'(fse_pkg::HEX_DIGITS);
                     state_in  = fse_pkg::ST_SKIP;
                  end else begin
                     emit = 1'b1;
                  end
               end
            end
         end
         fse_pkg::ST_CONV: begin
            if (bcd_status.done) begin
               digits_in = bcd_status.digits;
               cnt_in    = 4'(fse_pkg::BCD_DIGITS);
               state_in  = fse_pkg::ST_SKIP;
            end
         end
         fse_pkg::ST_SKIP: begin
            if (cnt_ff > 4'd1 && top_nib == 4'd0) begin
               digits_in = {digits_ff[fse_pkg::DIGITS_WIDTH-5:0], 4'd0};
               cnt_in    = cnt_ff - 4'd1;
            end else begin
               state_in = fse_pkg::ST_EMIT;
            end
         end
         fse_pkg::ST_EMIT: begin
            if (out_free) begin
               emit = 1'b1;
               if (neg_ff) begin
                  emit_char = fse_pkg::CHAR_MINUS;
                  emit_last = 1'b0;
                  neg_in    = 1'b0;
               end else begin
                  emit_char = fse_pkg::digit_char(top_nib);
                  emit_last = (cnt_ff == 4'd1);
                  digits_in = {digits_ff[fse_pkg::DIGITS_WIDTH-5:0], 4'd0};
                  cnt_in    = cnt_ff - 4'd1;
                  if (cnt_ff == 4'd1) begin
                     state_in = fse_pkg::ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = fse_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;
      if (emit) begin
         total_in     = (total_ff == '1) ? total_ff : total_ff + 32'd1;
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_last_in  = emit_last;
         rsp_count_in = total_in;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fse_pkg::ST_IDLE;
         pend_ff      <= 1'b0;
         neg_ff       <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         neg_ff       <= neg_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      digits_ff    <= digits_in;
      cnt_ff       <= cnt_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ rtl/fse_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Format string expander checker
// Port-level assertions on the expander, bound to the top level.
// ----------------------------------------------------------------------------
module fse_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [39:0] req_tdata,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled result transaction keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result transaction changed");

   // No input is taken while a result is held back by the receiver.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while output register is blocked");

   // A string-argument character comes straight back as a one-character run.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] |=>
         rsp_tvalid && rsp_tlast && rsp_tdata[7:0] == $past(req_tdata[7:0]))
      else $error("string character not copied through");

   // The running count advances by exactly one between results.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tdata[39:8] != 32'hffffffff |=>
         !rsp_tvalid || rsp_tdata[39:8] == $past(rsp_tdata[39:8]) + 32'd1)
      else $error("character count did not advance by one");

endmodule

bind format_string_expander fse_checker u_fse_checker (.*);

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Format string expander testbench
// Drives format and string-argument characters into the expander. Runs a
// directed set of edge cases, then a mostly well-formed random stream, with
// bursty input and patterned output back-pressure. A scoreboard predicts
// every output character, its end-of-run flag and the running count, and
// checks each output transaction against the prediction.
// ----------------------------------------------------------------------------
module tb;

   localparam int          RANDOM_ITEMS = 192;
   localparam int          STALL_LIMIT  = 2000;
   localparam int          DRAIN_CYCLES = 60;
   localparam logic [7:0]  CHAR_Q       = 8'h71;
   localparam logic [7:0]  CHAR_UPPER_A = 8'h41;

   typedef struct {
      bit [7:0]  out_char;
      bit        last_of_run;
      bit [31:0] chars_so_far;
   } expected_char_type;

   class char_scoreboard_type;
      bit                pending_percent;
      bit [31:0]         char_total;
      expected_char_type expected_chars[$];
      int unsigned       error_count;

      function void push_char(bit [7:0] c);
         expected_char_type beat;
         if (char_total != 32'hffff_ffff) begin
            char_total++;
         end
         beat.out_char     = c;
         beat.last_of_run  = 1'b0;
         beat.chars_so_far = char_total;
         expected_chars.push_back(beat);
      endfunction

      function void push_number(bit [31:0] mag, bit [31:0] radix);
         string    digit_set = "0123456789abcdef";
         bit [7:0] digit_buf[12];
         int       len;
         len = 0;
         do begin
            digit_buf[len] = digit_set[mag % radix];
            len++;
            mag = mag / radix;
         end while (mag != 0 && len < 12);
         while (len > 0) begin
            len--;
            push_char(digit_buf[len]);
         end
      endfunction

      function void predict_expansion(bit mode, bit [7:0] ch, bit [31:0] arg);
         int first;
         first = expected_chars.size();
         if (mode) begin
            push_char(ch);
         end else if (!pending_percent) begin
            if (ch == fse_pkg::CHAR_PERCENT) begin
               pending_percent = 1'b1;
            end else begin
               push_char(ch);
            end
         end else begin
            pending_percent = 1'b0;
            case (ch)
               fse_pkg::CHAR_C: push_char(arg[7:0]);
               fse_pkg::CHAR_S: ;
               fse_pkg::CHAR_D: begin
                  if (arg[31]) begin
                     push_char(fse_pkg::CHAR_MINUS);
                     push_number(~arg + 32'd1, 10);
                  end else begin
                     push_number(arg, 10);
                  end
               end
               fse_pkg::CHAR_X: push_number(arg, 16);
               default: push_char(ch);
            endcase
         end
         if (expected_chars.size() > first) begin
            expected_chars[expected_chars.size() - 1].last_of_run = 1'b1;
         end
      endfunction

      function void check_char(bit [7:0] c, bit last, bit [31:0] count);
         expected_char_type want;
         if (expected_chars.size() == 0) begin
            $error("unexpected character transaction: out_char %h", c);
            error_count++;
            return;
         end
         want = expected_chars.pop_front();
         if (c != want.out_char) begin
            $error("out_char: expected %h, got %h", want.out_char, c);
            error_count++;
         end
         if (last != want.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run, last);
            error_count++;
         end
         if (count != want.chars_so_far) begin
            $error("chars_so_far: expected %0d, got %0d", want.chars_so_far, count);
            error_count++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // char_code [7:0], arg_bits [39:8]
   logic [0:0]  req_tuser  = '0;   // mode [0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // out_char [7:0], chars_so_far [39:8]
   logic        rsp_tlast;

   char_scoreboard_type sb = new();

   int unsigned items_sent;
   int unsigned burst_left;
   int unsigned idle_cycles;
   int unsigned stall_phase_left;
   int unsigned stall_style;
   int unsigned pattern_count;

   format_string_expander dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      pattern_count <= pattern_count + 1;
      if (stall_phase_left == 0) begin
         stall_style      <= $urandom_range(0, 3);
         stall_phase_left <= $urandom_range(20, 120);
      end else begin
         stall_phase_left <= stall_phase_left - 1;
      end
      case (stall_style)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (pattern_count % 4 == 0);
         default: rsp_tready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_char(rsp_tdata[7:0], rsp_tlast, rsp_tdata[39:8]);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_req(input bit mode, input bit [7:0] ch, input bit [31:0] arg);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {arg, ch};
      req_tuser  <= mode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.predict_expansion(mode, ch, arg);
      items_sent++;
   endtask

   task automatic send_conversion(input bit [7:0] conv, input bit [31:0] arg);
      send_req(1'b0, fse_pkg::CHAR_PERCENT, $urandom);
      send_req(1'b0, conv, arg);
   endtask

   function automatic bit [31:0] random_arg();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 20);
         1: begin
            case ($urandom_range(0, 4))
               0: return 32'h0000_0000;
               1: return 32'h0000_0001;
               2: return 32'h7fff_ffff;
               3: return 32'h8000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         2: return ~32'($urandom_range(0, 1000)) + 32'd1;
         3: return $urandom >> $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      bit [7:0]    ch;
      bit [7:0]    conv;
      int unsigned random_target;
      int unsigned string_len;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_req(1'b0, 8'h00, 32'h0);
      send_req(1'b0, 8'hff, 32'hffff_ffff);
      send_req(1'b1, 8'h00, 32'h0);
      send_req(1'b1, 8'hff, 32'hffff_ffff);
      send_conversion(fse_pkg::CHAR_C, 32'hffff_ffff);
      send_conversion(fse_pkg::CHAR_C, 32'h0000_0000);
      send_conversion(fse_pkg::CHAR_D, 32'h8000_0000);
      send_conversion(fse_pkg::CHAR_D, 32'h7fff_ffff);
      send_conversion(fse_pkg::CHAR_D, 32'h0000_0000);
      send_conversion(fse_pkg::CHAR_X, 32'hffff_ffff);
      send_conversion(fse_pkg::CHAR_X, 32'h0000_0000);
      send_conversion(fse_pkg::CHAR_PERCENT, 32'h0);
      send_req(1'b0, fse_pkg::CHAR_PERCENT, 32'h0);
      send_req(1'b1, CHAR_UPPER_A, 32'h0);
      send_req(1'b0, fse_pkg::CHAR_D, 32'hffff_ffff);
      send_conversion(fse_pkg::CHAR_S, 32'h1234_5678);
      send_conversion(CHAR_Q, 32'h0);
      // A trailing percent stays pending into the random stream.
      send_req(1'b0, fse_pkg::CHAR_PERCENT, 32'h0);

      random_target = items_sent + RANDOM_ITEMS;
      while (items_sent < random_target) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               do ch = 8'($urandom); while (ch == fse_pkg::CHAR_PERCENT);
               send_req(1'b0, ch, $urandom);
            end
            3, 4, 5, 6: begin
               case ($urandom_range(0, 4))
                  0: conv = fse_pkg::CHAR_C;
                  1: conv = fse_pkg::CHAR_D;
                  2: conv = fse_pkg::CHAR_X;
                  3: conv = fse_pkg::CHAR_S;
                  default: begin
                     do conv = 8'($urandom);
                     while (conv inside {fse_pkg::CHAR_C, fse_pkg::CHAR_D,
                                         fse_pkg::CHAR_S, fse_pkg::CHAR_X});
                  end
               endcase
               send_conversion(conv, random_arg());
               if (conv == fse_pkg::CHAR_S) begin
                  string_len = $urandom_range(0, 6);
                  repeat (string_len) send_req(1'b1, 8'($urandom), $urandom);
               end
            end
            7: send_req(1'b1, 8'($urandom), $urandom);
            default: send_req(1'($urandom_range(0, 1)), 8'($urandom), random_arg());
         endcase
      end

      req_tvalid <= 1'b0;
      while (sb.expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.error_count == 0 && sb.expected_chars.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/fse_pkg.sv
rtl/fse_bcd.sv
rtl/format_string_expander.sv
rtl/fse_checker.sv
sim/tb.sv
